// ===== rtl/pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types and constants for the PCM block mixer with peak limiter.
// ----------------------------------------------------------------------------
package pbm_pkg;

	typedef enum logic [1:0] {
		CMD_ACC   = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_FRAMES   = 2'd1;
	localparam logic [1:0] REG_SILENCE  = 2'd2;

	localparam logic [3:0]  CH_RESET  = 4'd2;
	localparam logic [11:0] FR_RESET  = 12'd480;
	localparam logic [7:0]  SIL_RESET = 8'd20;

	localparam int LIMIT_LEVEL = 32767;
	localparam int CLAMP_HIGH  = 32767;
	localparam int CLAMP_LOW   = -32768;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [10:0] frame;
		logic [2:0]  chan;
		logic [15:0] sample;
	} req_t;

	typedef struct packed {
		logic [15:0] sample_out;
		logic        audible;
		logic [23:0] block_peak;
		logic [7:0]  silent_run;
		logic        epoch_end;
	} res_t;

endpackage

// ===== rtl/pbm_ram.sv =====
// ----------------------------------------------------------------------------
// pbm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/pbm_front.sv =====
// ----------------------------------------------------------------------------
// pbm_front
// Accepts requests into a two-entry queue; hands them to the back end.
// ----------------------------------------------------------------------------
module pbm_front
	import pbm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output logic avail,
	output req_t head
);
	req_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/pbm_back.sv =====
// ----------------------------------------------------------------------------
// pbm_back
// After reset clears the mix store; executes accumulate, close scan, read.
// ----------------------------------------------------------------------------
module pbm_back
	import pbm_pkg::*;
#(
	parameter int MAX_FRAMES   = 2048,
	parameter int MAX_CHANNELS = 8,
	parameter int ACC_WIDTH    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  channel_count,
	input  logic [11:0] block_frames,
	input  logic [7:0]  silence_limit,
	input  logic        avail,
	input  req_t        head,
	output logic        pop,
	output logic        res_valid,
	output res_t        res
);
	localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_CHANNELS + 1);
	localparam int FW    = $clog2(MAX_FRAMES + 1);
	localparam int SW    = AW + 1;
	localparam int DW    = ACC_WIDTH + 15;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RD    = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t         state_q;
	req_t           req_q;
	logic [AW-1:0]  slot_q;
	logic           inb_q;
	logic [SW-1:0]  scan_q;
	logic [SW-1:0]  n_q;
	logic           scan_v_q;
	logic [ACC_WIDTH-1:0] peak_q, pk_acc_q;
	logic [7:0]     silent_q;
	logic           epoch_q;
	logic           sign_q;
	logic [DW-1:0]  num_q, quo_q;
	logic [ACC_WIDTH:0] rem_q;
	logic [5:0]     bit_q;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [ACC_WIDTH-1:0] wdata, rdata;

	pbm_ram #(.WIDTH(ACC_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [CW-1:0] ch_eff;
	logic [FW-1:0] fr_eff;
	logic [7:0]    lim_eff;
	always_comb begin
		if (channel_count == 4'd0) ch_eff = CW'(1);
		else if (32'(channel_count) > MAX_CHANNELS) ch_eff = CW'(MAX_CHANNELS);
		else ch_eff = CW'(channel_count);
		if (block_frames == 12'd0) fr_eff = FW'(1);
		else if (32'(block_frames) > MAX_FRAMES) fr_eff = FW'(MAX_FRAMES);
		else fr_eff = FW'(block_frames);
		lim_eff = (silence_limit == 8'd0) ? 8'd1 : silence_limit;
	end

	logic inb;
	logic [AW+CW:0] slot_full;
	assign inb = (32'(head.frame) < 32'(fr_eff)) && (32'(head.chan) < 32'(ch_eff));
	assign slot_full = (AW+CW+1)'(head.frame) * (AW+CW+1)'(ch_eff) + (AW+CW+1)'(head.chan);

	logic signed [ACC_WIDTH:0] acc_sum;
	logic signed [ACC_WIDTH-1:0] acc_sat;
	localparam logic signed [ACC_WIDTH:0] AMAX = (ACC_WIDTH+1)'((64'd1 << (ACC_WIDTH-1)) - 1);
	localparam logic signed [ACC_WIDTH:0] AMIN = -AMAX - 1;
	always_comb begin
		acc_sum = $signed({rdata[ACC_WIDTH-1], rdata})
			+ (ACC_WIDTH+1)'($signed(req_q.sample));
		if (acc_sum > AMAX) acc_sat = AMAX[ACC_WIDTH-1:0];
		else if (acc_sum < AMIN) acc_sat = AMIN[ACC_WIDTH-1:0];
		else acc_sat = acc_sum[ACC_WIDTH-1:0];
	end

	logic [ACC_WIDTH-1:0] absv;
	assign absv = rdata[ACC_WIDTH-1] ? (~rdata + 1'b1) : rdata;

	logic [ACC_WIDTH:0] rem_sh;
	assign rem_sh = {rem_q[ACC_WIDTH-1:0], num_q[DW-1]};

	logic [8:0] run_inc;
	logic       aud;
	assign aud = (pk_acc_q != '0);
	assign run_inc = aud ? 9'd0 : ((silent_q == 8'd255) ? 9'd255 : {1'b0, silent_q} + 9'd1);

	logic ep_end;
	logic scan_end;
	assign ep_end   = (epoch_q || aud) && (run_inc[7:0] >= lim_eff);
	assign scan_end = (scan_q == n_q + 1'b1) || (scan_q > n_q);

	logic signed [DW:0] lim_sv;
	logic [15:0]        clamp_out;
	always_comb begin
		lim_sv = sign_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		if (lim_sv > $signed((DW+1)'(CLAMP_HIGH)))
			clamp_out = 16'(CLAMP_HIGH);
		else if (lim_sv < $signed((DW+1)'(CLAMP_LOW)))
			clamp_out = 16'(CLAMP_LOW);
		else
			clamp_out = lim_sv[15:0];
	end

	logic res_fire;
	assign res_fire = ((state_q == S_EXEC) && !(req_q.cmd == CMD_READ && inb_q))
		|| ((state_q == S_SCAN) && scan_end) || (state_q == S_DONE);

	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = '0;
		raddr = slot_q;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = scan_q[AW-1:0];
			end
			S_IDLE: raddr = slot_full[AW-1:0];
			S_EXEC: begin
				we    = inb_q && (req_q.cmd == CMD_ACC || req_q.cmd == CMD_READ);
				wdata = (req_q.cmd == CMD_ACC) ? acc_sat : '0;
			end
			S_SCAN: raddr = scan_q[AW-1:0];
			default: ;
		endcase
	end

	assign pop = (state_q == S_IDLE) && avail;

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q  <= head;
			slot_q <= slot_full[AW-1:0];
			inb_q  <= inb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			scan_q    <= '0;
			n_q       <= '0;
			scan_v_q  <= 1'b0;
			peak_q    <= '0;
			pk_acc_q  <= '0;
			silent_q  <= '0;
			epoch_q   <= 1'b0;
			res_valid <= 1'b0;
			res       <= '0;
			sign_q    <= 1'b0;
			num_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			bit_q     <= '0;
		end else begin
			res_valid <= res_fire;
			unique case (state_q)
				S_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) state_q <= S_RD;
				end
				S_RD: begin
					if (req_q.cmd == CMD_CLOSE) begin
						scan_q   <= '0;
						n_q      <= SW'(32'(fr_eff) * 32'(ch_eff));
						scan_v_q <= 1'b0;
						pk_acc_q <= '0;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res <= '0;
					if (req_q.cmd == CMD_READ && inb_q) begin
						sign_q <= rdata[ACC_WIDTH-1];
						if (32'(peak_q) > LIMIT_LEVEL) begin
							num_q   <= DW'(absv) * DW'(LIMIT_LEVEL);
							quo_q   <= '0;
							rem_q   <= '0;
							bit_q   <= 6'(DW);
							state_q <= S_DIV;
						end else begin
							quo_q   <= DW'(absv);
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					scan_v_q <= (scan_q < n_q);
					if (scan_v_q && absv > pk_acc_q) pk_acc_q <= absv;
					if (scan_end) begin
						peak_q <= pk_acc_q;
						res <= '{sample_out: 16'd0, audible: aud,
							block_peak: 24'(pk_acc_q), silent_run: run_inc[7:0],
							epoch_end: ep_end};
						if (ep_end) begin
							epoch_q  <= 1'b0;
							silent_q <= '0;
						end else begin
							epoch_q  <= epoch_q || aud;
							silent_q <= run_inc[7:0];
						end
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, peak_q}) begin
						rem_q <= rem_sh - {1'b0, peak_q};
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					num_q <= {num_q[DW-2:0], 1'b0};
					bit_q <= bit_q - 1'b1;
					if (bit_q == 6'd1) state_q <= S_DONE;
				end
				S_DONE: begin
					res <= '{sample_out: clamp_out, audible: 1'b0, block_peak: 24'd0,
						silent_run: 8'd0, epoch_end: 1'b0};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/pcm_block_mixer_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// pcm_block_mixer_peak_limiter
// Mixes PCM samples into an interleaved block store with a peak limiter.
// ----------------------------------------------------------------------------
// Usage: pulse start with command, frame_index, channel_index, sample_in while
// busy is low. Each request yields one result, marked by done for one cycle.
// busy is high while the two-entry request queue is full.
// Accumulate: the slot is read, added to with saturation and written back;
// the back end takes no new request until it is idle again. Read and clear:
// the slot is read and cleared; with peak above 32767 the restoring divider
// scales the sample by 32767/peak (one quotient bit a cycle).
// Close: scans frames*channels slots, one slot a cycle over the RAM read port.
// Sustained rate is set by the back end; the queue hides front-side gaps.
// After reset the store is cleared one slot a cycle, MAX_FRAMES*MAX_CHANNELS
// slots; requests queue meanwhile (busy once the queue fills). Config writes
// via cfg_we/cfg_index/cfg_data are taken at any time but must be done idle.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module pcm_block_mixer_peak_limiter
	import pbm_pkg::*;
#(
	parameter int MAX_FRAMES   = 2048,
	parameter int MAX_CHANNELS = 8,
	parameter int ACC_WIDTH    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [10:0] frame_index,
	input  logic [2:0]  channel_index,
	input  logic signed [15:0] sample_in,
	output logic        done,
	output logic signed [15:0] sample_out,
	output logic        audible,
	output logic [23:0] block_peak,
	output logic [7:0]  silent_run,
	output logic        epoch_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	logic [3:0]  ch_q;
	logic [11:0] fr_q;
	logic [7:0]  sil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q  <= CH_RESET;
			fr_q  <= FR_RESET;
			sil_q <= SIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNELS: ch_q  <= cfg_data[3:0];
				REG_FRAMES:   fr_q  <= cfg_data;
				REG_SILENCE:  sil_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	req_t in_req, head;
	res_t res;
	logic full, avail, pop;

	assign in_req = '{cmd: command, frame: frame_index, chan: channel_index,
		sample: sample_in};
	assign busy = full;

	pbm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(start && !full), .push_req(in_req),
		.full(full), .pop(pop), .avail(avail), .head(head)
	);

	pbm_back #(
		.MAX_FRAMES(MAX_FRAMES), .MAX_CHANNELS(MAX_CHANNELS), .ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .channel_count(ch_q), .block_frames(fr_q),
		.silence_limit(sil_q), .avail(avail), .head(head), .pop(pop),
		.res_valid(done), .res(res)
	);

	assign sample_out = res.sample_out;
	assign audible    = res.audible;
	assign block_peak = res.block_peak;
	assign silent_run = res.silent_run;
	assign epoch_end  = res.epoch_end;
endmodule

// ===== rtl/pbm_checker.sv =====
// ----------------------------------------------------------------------------
// pbm_checker
// Port-level checks on the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module pbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        audible,
	input logic [23:0] block_peak,
	input logic        epoch_end,
	input logic [15:0] sample_out,
	input logic [7:0]  silent_run
);
	a_aud_peak: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (audible == (block_peak != 24'd0))) else $error("audible mismatch");
	a_end_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && epoch_end) |-> (!audible && silent_run != 8'd0))
		else $error("epoch end on audible block");
	a_close_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(done && audible) |-> (sample_out == 16'd0)) else $error("mixed fields");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
endmodule

bind pcm_block_mixer_peak_limiter pbm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .done(done), .audible(audible),
	.block_peak(block_peak), .epoch_end(epoch_end), .sample_out(sample_out),
	.silent_run(silent_run)
);
